>>> src/lru_key_value_cache_unit_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define LKV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define LKV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define LKV_ASSERT(lbl, prop, msg)
`define LKV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/lrukv_pkg.sv
`default_nettype none

package lrukv_pkg;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Fixed widths of the ports
    localparam int IO_BITS  = 32;
    localparam int CFG_BITS = 5;

    // Capacity register after reset
    localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

    // Read value returned on a miss
    localparam logic [IO_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Outcome of one pass over the entries
    typedef struct packed {
        logic has_match;
        logic has_oldest;
        logic has_free;
    } t_scan_flags;

endpackage

`default_nettype wire

>>> src/lrukv_store.sv
`default_nettype none

module lrukv_store #(
    parameter int DEPTH     = 16,
    parameter int IW        = 4,
    parameter int AW        = 4,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [IW-1:0]        i_rd_addr,
    input  wire logic                 i_wr_en,
    input  wire logic [IW-1:0]        i_wr_addr,
    input  wire logic [KEY_BITS-1:0]  i_wr_key,
    input  wire logic [DATA_BITS-1:0] i_wr_data,
    input  wire logic [AW-1:0]        i_wr_age,
    input  wire logic                 i_set_valid,
    input  wire logic [IW-1:0]        i_set_addr,
    output logic                      o_rd_valid,
    output logic [KEY_BITS-1:0]       o_rd_key,
    output logic [DATA_BITS-1:0]      o_rd_data,
    output logic [AW-1:0]             o_rd_age
);

    localparam int EW = KEY_BITS + DATA_BITS + AW;

    logic [EW-1:0]    r_mem [DEPTH];
    logic [EW-1:0]    r_rd_word;
    logic             r_rd_valid;
    logic [DEPTH-1:0] r_valid;

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_key, i_wr_data, i_wr_age};
        end
    end

    // Registered read of the entry and its valid bit
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Valid bits: cleared by reset, set on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_set_valid) begin
            r_valid[i_set_addr] <= 1'b1;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_key   = r_rd_word[EW-1 -: KEY_BITS];
    assign o_rd_data  = r_rd_word[AW +: DATA_BITS];
    assign o_rd_age   = r_rd_word[AW-1:0];

endmodule

`default_nettype wire

>>> src/lrukv_scan.sv
`default_nettype none

module lrukv_scan #(
    parameter int IW        = 4,
    parameter int AW        = 4,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_vld,
    input  wire logic [IW-1:0]        i_idx,
    input  wire logic                 i_ent_valid,
    input  wire logic [KEY_BITS-1:0]  i_ent_key,
    input  wire logic [DATA_BITS-1:0] i_ent_data,
    input  wire logic [AW-1:0]        i_ent_age,
    input  wire logic [KEY_BITS-1:0]  i_key,
    output lrukv_pkg::t_scan_flags    o_flags,
    output logic [IW-1:0]             o_match_idx,
    output logic [AW-1:0]             o_match_age,
    output logic [DATA_BITS-1:0]      o_match_data,
    output logic [IW-1:0]             o_oldest_idx,
    output logic [AW-1:0]             o_oldest_age,
    output logic [IW-1:0]             o_free_idx
);

    lrukv_pkg::t_scan_flags r_flags;
    logic [IW-1:0]          r_match_idx;
    logic [AW-1:0]          r_match_age;
    logic [DATA_BITS-1:0]   r_match_data;
    logic [IW-1:0]          r_oldest_idx;
    logic [AW-1:0]          r_oldest_age;
    logic [IW-1:0]          r_free_idx;

    logic take_match;
    logic take_oldest;
    logic take_free;

    // Keep the first match, the first oldest entry and the first free slot
    always_comb begin
        take_match  = i_vld && i_ent_valid && !r_flags.has_match && (i_ent_key == i_key);
        take_oldest = i_vld && i_ent_valid &&
                      (!r_flags.has_oldest || (i_ent_age > r_oldest_age));
        take_free   = i_vld && !i_ent_valid && !r_flags.has_free;
    end

    // Flags: clear on reset and at the start of each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else begin
            if (take_match) begin
                r_flags.has_match <= 1'b1;
            end
            if (take_oldest) begin
                r_flags.has_oldest <= 1'b1;
            end
            if (take_free) begin
                r_flags.has_free <= 1'b1;
            end
        end
    end

    // Capture the winning entries
    always_ff @(posedge i_clk) begin
        if (take_match) begin
            r_match_idx  <= i_idx;
            r_match_age  <= i_ent_age;
            r_match_data <= i_ent_data;
        end
        if (take_oldest) begin
            r_oldest_idx <= i_idx;
            r_oldest_age <= i_ent_age;
        end
        if (take_free) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags      = r_flags;
    assign o_match_idx  = r_match_idx;
    assign o_match_age  = r_match_age;
    assign o_match_data = r_match_data;
    assign o_oldest_idx = r_oldest_idx;
    assign o_oldest_age = r_oldest_age;
    assign o_free_idx   = r_free_idx;

endmodule

`default_nettype wire

>>> src/lru_key_value_cache_unit.sv
// A get runs a search pass and, on a hit, an age update pass before its result; a put
// runs both passes. A new item is taken only once the last one is done, as set by
// the single entry memory: one read pass to search, one read-modify-write pass for ages.
// Reset (synchronous, active low) clears all entries, occupancy and the handshakes,
// and sets the capacity register to 16; no clearing pass is needed.
`default_nettype none
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lrukv_pkg::CFG_BITS-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_opcode,
    input  wire logic signed [31:0]             i_lookup_key,
    input  wire logic signed [31:0]             i_store_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_hit,
    output logic signed [31:0]                  o_read_value
);

    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW   = IW;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > lrukv_pkg::CFG_BITS) ? CW : lrukv_pkg::CFG_BITS;
    localparam logic [IW-1:0]   LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [CMPW-1:0] MAX_CMP  = CMPW'(MAX_ENTRIES);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_DECIDE   = 3'd3;
    localparam logic [2:0] ST_UPD      = 3'd4;
    localparam logic [2:0] ST_UPD_END  = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]                     r_state, n_state;
    logic [IW-1:0]                  r_idx, n_idx;
    logic                           r_pipe_vld;
    logic                           r_pipe_scan;
    logic [IW-1:0]                  r_pipe_idx;
    logic                           r_op;
    logic [KEY_BITS-1:0]            r_key;
    logic [DATA_BITS-1:0]           r_val;
    logic [CW-1:0]                  r_count, n_count;
    logic [lrukv_pkg::CFG_BITS-1:0] r_cap;
    logic [IW-1:0]                  r_tgt, n_tgt;
    logic [AW-1:0]                  r_thr, n_thr;
    logic                           r_wr_kd, n_wr_kd;
    logic                           r_res_hit, n_res_hit;
    logic [31:0]                    r_res_data, n_res_data;
    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [31:0]                    r_out_data;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   rd_en;
    logic                   wr_en;
    logic                   set_valid;
    logic [CMPW-1:0]        cap_eff;
    logic [CMPW-1:0]        count_cmp;
    logic                   full;
    logic [KEY_BITS-1:0]    key_ext;
    logic [DATA_BITS-1:0]   val_ext;
    logic [KEY_BITS-1:0]    wr_key;
    logic [DATA_BITS-1:0]   wr_data;
    logic [AW-1:0]          wr_age;

    logic                   ent_valid;
    logic [KEY_BITS-1:0]    ent_key;
    logic [DATA_BITS-1:0]   ent_data;
    logic [AW-1:0]          ent_age;

    lrukv_pkg::t_scan_flags      flags;
    logic [IW-1:0]               match_idx;
    logic [AW-1:0]               match_age;
    logic [DATA_BITS-1:0]        match_data;
    logic signed [DATA_BITS-1:0] match_data_s;
    logic [IW-1:0]               oldest_idx;
    logic [AW-1:0]               oldest_age;
    logic [IW-1:0]               free_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_out_valid && i_out_ready;
    assign key_ext     = KEY_BITS'(i_lookup_key);
    assign val_ext     = DATA_BITS'(i_store_value);
    assign match_data_s = match_data;

    // Clamp the capacity register into 1..MAX_ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CMPW'(1);
        end else if (CMPW'(r_cap) > MAX_CMP) begin
            cap_eff = MAX_CMP;
        end else begin
            cap_eff = CMPW'(r_cap);
        end
        count_cmp = CMPW'(r_count);
        full      = (count_cmp >= cap_eff) || (count_cmp >= MAX_CMP);
    end

    // Sequencer: scan pass, decision, age update pass (skipped on a get miss), result
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_tgt      = r_tgt;
        n_thr      = r_thr;
        n_wr_kd    = r_wr_kd;
        n_res_hit  = r_res_hit;
        n_res_data = r_res_data;
        set_valid  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_idx      = '0;
                n_state    = ST_UPD;
                n_res_hit  = flags.has_match;
                n_res_data = flags.has_match ? 32'(match_data_s) : lrukv_pkg::MISS_VALUE;
                if (flags.has_match) begin
                    n_tgt   = match_idx;
                    n_thr   = match_age;
                    n_wr_kd = (r_op == lrukv_pkg::OP_PUT);
                end else if (r_op == lrukv_pkg::OP_GET) begin
                    n_state = ST_DONE;
                end else if (full) begin
                    n_tgt   = oldest_idx;
                    n_thr   = oldest_age;
                    n_wr_kd = 1'b1;
                end else begin
                    // Insert into the lowest free slot; every valid entry ages
                    n_tgt     = free_idx;
                    n_thr     = AW'(r_count);
                    n_wr_kd   = 1'b1;
                    set_valid = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ST_UPD: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_UPD_END;
                end
            end
            ST_UPD_END: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (r_op == lrukv_pkg::OP_PUT || !r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_cap      <= lrukv_pkg::CAP_RESET;
            r_pipe_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pipe_vld <= rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Item and decision registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pipe_idx  <= r_idx;
        r_pipe_scan <= (r_state == ST_SCAN);
        r_tgt       <= n_tgt;
        r_thr       <= n_thr;
        r_wr_kd     <= n_wr_kd;
        r_res_hit   <= n_res_hit;
        r_res_data  <= n_res_data;
        if (in_xfer) begin
            r_op  <= i_opcode;
            r_key <= key_ext;
            r_val <= val_ext;
        end
    end

    // Output register: load a get result when the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && r_op == lrukv_pkg::OP_GET &&
                     (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_hit  <= r_res_hit;
            r_out_data <= r_res_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_data;

    // Memory access: read in both passes, write back in the update pass
    assign rd_en = (r_state == ST_SCAN) || (r_state == ST_UPD);
    assign wr_en = r_pipe_vld && !r_pipe_scan;

    // Age the younger entries; the target becomes most recent
    always_comb begin
        wr_key  = ent_key;
        wr_data = ent_data;
        wr_age  = ent_age;
        if (ent_valid && (ent_age < r_thr)) begin
            wr_age = ent_age + 1'b1;
        end
        if (r_pipe_idx == r_tgt) begin
            wr_age = '0;
            if (r_wr_kd) begin
                wr_key  = r_key;
                wr_data = r_val;
            end
        end
    end

    lrukv_store #(
        .DEPTH     (MAX_ENTRIES),
        .IW        (IW),
        .AW        (AW),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (r_idx),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_pipe_idx),
        .i_wr_key    (wr_key),
        .i_wr_data   (wr_data),
        .i_wr_age    (wr_age),
        .i_set_valid (set_valid),
        .i_set_addr  (n_tgt),
        .o_rd_valid  (ent_valid),
        .o_rd_key    (ent_key),
        .o_rd_data   (ent_data),
        .o_rd_age    (ent_age)
    );

    lrukv_scan #(
        .IW        (IW),
        .AW        (AW),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_xfer),
        .i_vld        (r_pipe_vld && r_pipe_scan),
        .i_idx        (r_pipe_idx),
        .i_ent_valid  (ent_valid),
        .i_ent_key    (ent_key),
        .i_ent_data   (ent_data),
        .i_ent_age    (ent_age),
        .i_key        (r_key),
        .o_flags      (flags),
        .o_match_idx  (match_idx),
        .o_match_age  (match_age),
        .o_match_data (match_data),
        .o_oldest_idx (oldest_idx),
        .o_oldest_age (oldest_age),
        .o_free_idx   (free_idx)
    );

    // Write-back never lands on the entry being read in the same cycle
    `LKV_ASSERT(a_no_rw_overlap, (wr_en && rd_en) |-> (r_pipe_idx != r_idx), "rw overlap")
    // Occupancy stays within the number of entries
    `LKV_ASSERT(a_count_bound, CMPW'(r_count) <= MAX_CMP, "occupancy overflow")
    // Occupancy only grows, one insert at a time
    `LKV_ASSERT(a_count_step, ##1 ((r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)), "occupancy jump")
    // No write-back while the search pass is reading
    `LKV_ASSERT(a_scan_no_write, (r_state == ST_SCAN) |-> !wr_en, "write during scan")

endmodule

`default_nettype wire

>>> tb/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;

    localparam int NUM_SLOTS     = 16;
    localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 16;
    localparam int POOL_SIZE     = 40;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key;
        logic [31:0] value;
    } t_cache_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
    } t_read_result;

    // DUT pins
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [lrukv_pkg::CFG_BITS-1:0] i_cfg_data    = '0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_ready;
    logic                           i_opcode      = lrukv_pkg::OP_GET;
    logic signed [31:0]             i_lookup_key  = '0;
    logic signed [31:0]             i_store_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready   = 1'b0;
    logic                           o_hit;
    logic signed [31:0]             o_read_value;

    // Predicted cache contents
    logic [lrukv_pkg::CFG_BITS-1:0] capacity_cfg;
    logic                slot_valid [NUM_SLOTS];
    logic [31:0]         slot_key   [NUM_SLOTS];
    logic [31:0]         slot_data  [NUM_SLOTS];
    int                  slot_rank  [NUM_SLOTS];
    int                  fill_count;

    // Stimulus and scoreboard state
    t_cache_req   pending_requests[$];
    t_read_result awaited_reads[$];
    t_cache_req   next_req;
    logic [31:0]  key_pool [POOL_SIZE];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           mismatch_count = 0;
    bit           in_fire  = 1'b0;
    bit           cfg_fire = 1'b0;

    lru_key_value_cache_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_lookup_key  (i_lookup_key),
        .i_store_value (i_store_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Move slot to rank 0; every younger valid entry ages by one
    function automatic void make_most_recent(input int slot);
        int rank;
        rank = slot_rank[slot];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && slot_rank[i] < rank) begin
                slot_rank[i]++;
            end
        end
        slot_rank[slot] = 0;
    endfunction

    // Apply one request to the predicted cache; return 1 when it yields a read result
    function automatic bit cache_access(input t_cache_req req, output t_read_result res);
        int  slot;
        int  victim;
        int  oldest;
        int  limit;
        bit  placed;
        slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot < 0 && slot_valid[i] && slot_key[i] == req.key) begin
                slot = i;
            end
        end
        res.hit        = 1'b0;
        res.read_value = lrukv_pkg::MISS_VALUE;

        if (req.opcode == lrukv_pkg::OP_GET) begin
            if (slot >= 0) begin
                make_most_recent(slot);
                res.hit        = 1'b1;
                res.read_value = slot_data[slot];
            end
            return 1'b1;
        end

        // Update in place
        if (slot >= 0) begin
            slot_data[slot] = req.value;
            make_most_recent(slot);
            return 1'b0;
        end

        // Zero acts as one, anything past the slot count as the slot count
        if (capacity_cfg == 0) begin
            limit = 1;
        end else if (capacity_cfg > NUM_SLOTS) begin
            limit = NUM_SLOTS;
        end else begin
            limit = capacity_cfg;
        end

        // Full, or over a lowered capacity: replace the least recent entry
        if (fill_count >= limit) begin
            victim = 0;
            oldest = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_valid[i] && slot_rank[i] > oldest) begin
                    victim = i;
                    oldest = slot_rank[i];
                end
            end
            slot_key[victim]  = req.key;
            slot_data[victim] = req.value;
            make_most_recent(victim);
            return 1'b0;
        end

        // Insert into the lowest free slot as most recent
        placed = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!placed && !slot_valid[i]) begin
                for (int j = 0; j < NUM_SLOTS; j++) begin
                    if (slot_valid[j]) begin
                        slot_rank[j]++;
                    end
                end
                slot_valid[i] = 1'b1;
                slot_key[i]   = req.key;
                slot_data[i]  = req.value;
                slot_rank[i]  = 0;
                fill_count++;
                placed = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Drive requests and output ready on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // hold the payload until the transfer
        end else if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_requests.pop_front();
            i_in_valid    <= 1'b1;
            i_opcode      <= next_req.opcode;
            i_lookup_key  <= next_req.key;
            i_store_value <= next_req.value;
        end else begin
            i_in_valid <= 1'b0;
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample transfers on the rising edge, check reads, then advance the prediction
    always @(posedge i_clk) begin : monitor
        t_read_result want;
        t_read_result pred;
        t_cache_req   seen;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_reads.size() == 0) begin
                    $error("read result with none pending: hit %0d, read_value 0x%08h",
                           o_hit, o_read_value);
                    mismatch_count++;
                end else begin
                    want = awaited_reads.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, o_hit);
                        mismatch_count++;
                    end
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected 0x%08h, actual 0x%08h",
                               want.read_value, o_read_value);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_fire) begin
                capacity_cfg = i_cfg_data;
            end
            if (in_fire) begin
                seen.opcode = i_opcode;
                seen.key    = i_lookup_key;
                seen.value  = i_store_value;
                if (cache_access(seen, pred)) begin
                    awaited_reads.push_back(pred);
                end
            end
        end
    end

    task automatic queue_req(input logic op, input logic [31:0] key, input logic [31:0] value);
        t_cache_req r;
        r.opcode = op;
        r.key    = key;
        r.value  = value;
        pending_requests.push_back(r);
    endtask

    // Wait until every request is taken and every read returned, then let puts finish
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || i_in_valid || awaited_reads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lrukv_pkg::CFG_BITS-1:0] cap);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: keys mostly from the first span entries of a pool, some fully random
    task automatic run_phase(input logic [lrukv_pkg::CFG_BITS-1:0] cap, input int count,
                             input int span, input int send_idle, input int recv_idle);
        logic [31:0] key;
        wait_for_drain();
        write_capacity(cap);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(span - 1)];
            end
            queue_req($urandom_range(1) ? lrukv_pkg::OP_PUT : lrukv_pkg::OP_GET, key, $urandom);
        end
    endtask

    initial begin : stimulus
        capacity_cfg = lrukv_pkg::CAP_RESET;
        fill_count   = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_rank[i]  = 0;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        send_idle_pct = 17;
        recv_idle_pct = 51;

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty cache, key and value extremes, update of a present key
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(lrukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(lrukv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(lrukv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_req(lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0000, 32'h5555_5555);
        queue_req(lrukv_pkg::OP_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        queue_req(lrukv_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
        wait_for_drain();

        // Capacity lowered below occupancy: inserts replace, occupancy holds
        write_capacity(5'd2);
        queue_req(lrukv_pkg::OP_PUT, 32'h0000_0055, 32'h0000_0001);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0055, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_PUT, 32'h0000_0066, 32'h0000_0002);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0066, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0055, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(lrukv_pkg::OP_PUT, 32'h0000_0055, 32'h0000_0003);
        queue_req(lrukv_pkg::OP_GET, 32'h0000_0055, 32'h0000_0000);

        // Random phases over several capacities, zero and out of range among them
        run_phase(5'd16, 150, 24, 17, 51);
        run_phase(5'd1, 120, 4, 17, 51);
        run_phase(5'd0, 100, 3, 51, 17);
        run_phase(5'd31, 140, 32, 51, 17);
        run_phase(5'd4, 170, 8, 0, 0);
        run_phase(lrukv_pkg::CFG_BITS'($urandom_range(15, 2)), 170, 20, 0, 0);
        wait_for_drain();

        if (mismatch_count == 0 && awaited_reads.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
